// ----- src/fktc_pkg.sv -----
// ----------------------------------------------------------------------------
// fktc_pkg
// Shared types and constants for the fan kick-start and tachometer controller.
// ----------------------------------------------------------------------------
package fktc_pkg;

    localparam int RPM_W           = 16;
    localparam int RPM_PER_EDGE_MS = 30000;
    localparam int DIVIDEND_W      = 31;
    localparam int DIV_CNT_W       = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd30;

    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_TOP_VALUE     = 3'd0;
    localparam logic [2:0] REG_MAX_RPM       = 3'd1;
    localparam logic [2:0] REG_SENSE_ENABLED = 3'd2;
    localparam logic [2:0] REG_KICK_LEVEL    = 3'd3;
    localparam logic [2:0] REG_KICK_MS       = 3'd4;
    localparam logic [2:0] REG_WINDOW_MS     = 3'd5;

    typedef enum logic [1:0] {
        MUL_EST,
        MUL_EDGE,
        MUL_CMP
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd;
        logic     div_init;
        logic     div_step;
        logic     div_fin;
        logic     cmp_load;
        logic     out_load;
    } fktc_cmd_t;

    typedef struct packed {
        logic win_closed;
        logic div_last;
        logic out_free;
    } fktc_stat_t;

endpackage

// ----- src/fan_kickstart_tach_controller.sv -----
// ----------------------------------------------------------------------------
// fan_kickstart_tach_controller
// Fan PWM duty control with start-up kick and tachometer speed measurement.
// ----------------------------------------------------------------------------
// One s_ beat is one millisecond tick: tach edges seen, plus an optional duty
// request flagged in s_tuser. Every accepted tick yields exactly one m_ beat
// with the PWM compare value, the applied duty, the speed and two flags.
// Registers sit behind the APB-style port at byte address 4*index; write them
// only while no tick is in flight.
// A tick passes through the update and check states, the compare and estimate
// multiplies and the output load; a tick that closes a measurement window also
// runs the 31-step restoring divider for the rpm. The next tick is accepted in
// the cycle after the result is loaded, so a new tick waits for the last one.
// The output register holds a finished beat while m_tready is low; the next
// tick is still accepted and worked on, and waits only at the output load.
// Reset clears the fan state, the kick and the window counters and loads the
// register defaults.
// ----------------------------------------------------------------------------
module fan_kickstart_tach_controller #(
    parameter int DUTY_FRACTION_BITS = 10,
    localparam int DW        = DUTY_FRACTION_BITS + 1,
    localparam int S_TDATA_W = ((DW + 2 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DW + 32 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tach_edges[1:0], duty_request[DW+1:2], zero padding
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // request_valid
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // compare_value[15:0], applied_duty[DW+15:16], speed_rpm[DW+31:DW+16], padding
    output logic [M_TDATA_W-1:0]            m_tdata,
    // kicking[0], rpm_updated[1]
    output logic [1:0]                      m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fktc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import fktc_pkg::*;

    fktc_cmd_t     cmd;
    fktc_stat_t    stat;
    logic [15:0]   top_value;
    logic [15:0]   max_rpm;
    logic          sense_enabled;
    logic [DW-1:0] kick_level;
    logic [15:0]   kick_ms;
    logic [15:0]   window_ms;
    logic [15:0]   compare_value;
    logic [DW-1:0] applied_duty;
    logic [15:0]   speed_rpm;
    logic          kicking;
    logic          rpm_updated;

    fktc_cfg #(
        .DUTY_FRACTION_BITS(DUTY_FRACTION_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .top_value    (top_value),
        .max_rpm      (max_rpm),
        .sense_enabled(sense_enabled),
        .kick_level   (kick_level),
        .kick_ms      (kick_ms),
        .window_ms    (window_ms)
    );

    fktc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fktc_dp #(
        .DUTY_FRACTION_BITS(DUTY_FRACTION_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .tach_edges   (s_tdata[1:0]),
        .request_valid(s_tuser),
        .duty_request (s_tdata[DW+1:2]),
        .top_value    (top_value),
        .max_rpm      (max_rpm),
        .sense_enabled(sense_enabled),
        .kick_level   (kick_level),
        .kick_ms      (kick_ms),
        .window_ms    (window_ms),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .compare_value(compare_value),
        .applied_duty (applied_duty),
        .speed_rpm    (speed_rpm),
        .kicking      (kicking),
        .rpm_updated  (rpm_updated)
    );

    assign m_tdata = M_TDATA_W'({speed_rpm, applied_duty, compare_value});
    assign m_tuser = {rpm_updated, kicking};

endmodule

// ----- src/fktc_cfg.sv -----
// ----------------------------------------------------------------------------
// fktc_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module fktc_cfg #(
    parameter int DUTY_FRACTION_BITS = 10,
    localparam int DW = DUTY_FRACTION_BITS + 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fktc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [15:0]                     top_value,
    output logic [15:0]                     max_rpm,
    output logic                            sense_enabled,
    output logic [DW-1:0]                   kick_level,
    output logic [15:0]                     kick_ms,
    output logic [15:0]                     window_ms
);
    import fktc_pkg::*;

    logic [15:0]   top_value_reg;
    logic [15:0]   max_rpm_reg;
    logic          sense_enabled_reg;
    logic [DW-1:0] kick_level_reg;
    logic [15:0]   kick_ms_reg;
    logic [15:0]   window_ms_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_value_reg     <= 16'd640;
            max_rpm_reg       <= 16'd3000;
            sense_enabled_reg <= 1'b1;
            kick_level_reg    <= DW'(307);
            kick_ms_reg       <= 16'd2000;
            window_ms_reg     <= 16'd1500;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_TOP_VALUE:     top_value_reg     <= pwdata[15:0];
                REG_MAX_RPM:       max_rpm_reg       <= pwdata[15:0];
                REG_SENSE_ENABLED: sense_enabled_reg <= pwdata[0];
                REG_KICK_LEVEL:    kick_level_reg    <= pwdata[DW-1:0];
                REG_KICK_MS:       kick_ms_reg       <= pwdata[15:0];
                REG_WINDOW_MS:     window_ms_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_TOP_VALUE:     prdata = {16'd0, top_value_reg};
            REG_MAX_RPM:       prdata = {16'd0, max_rpm_reg};
            REG_SENSE_ENABLED: prdata = {31'd0, sense_enabled_reg};
            REG_KICK_LEVEL:    prdata = 32'(kick_level_reg);
            REG_KICK_MS:       prdata = {16'd0, kick_ms_reg};
            REG_WINDOW_MS:     prdata = {16'd0, window_ms_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign top_value     = top_value_reg;
    assign max_rpm       = max_rpm_reg;
    assign sense_enabled = sense_enabled_reg;
    assign kick_level    = kick_level_reg;
    assign kick_ms       = kick_ms_reg;
    assign window_ms     = window_ms_reg;

endmodule

// ----- src/fktc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fktc_ctrl
// Sequencer for one tick: update, optional rpm division, PWM and estimate.
// ----------------------------------------------------------------------------
module fktc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  fktc_pkg::fktc_stat_t   stat,
    output fktc_pkg::fktc_cmd_t    cmd
);
    import fktc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPD   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_DINIT = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_DFIN  = 4'd5;
    localparam logic [3:0] S_CMUL  = 4'd6;
    localparam logic [3:0] S_EMUL  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_EST;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_EST;
                    state_next  = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                cmd.mul_en = 1'b1;
                if (stat.win_closed) begin
                    cmd.mul_sel = MUL_EDGE;
                    state_next  = S_DINIT;
                end else begin
                    cmd.mul_sel = MUL_CMP;
                    state_next  = S_EMUL;
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN: begin
                cmd.div_fin = 1'b1;
                state_next  = S_CMUL;
            end
            S_CMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CMP;
                state_next  = S_EMUL;
            end
            S_EMUL: begin
                cmd.cmp_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_EST;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && stat.div_last |=> state_reg == S_DFIN)
        else $error("divider did not finish after its last step");

    a_accept_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> state_reg == S_UPD)
        else $error("accepted tick not followed by update");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && !stat.out_free |=> state_reg == S_OUT)
        else $error("result dropped while output register busy");

endmodule

// ----- src/fktc_dp.sv -----
// ----------------------------------------------------------------------------
// fktc_dp
// Fan state, kick timer, tach window, shared multiplier, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module fktc_dp #(
    parameter int DUTY_FRACTION_BITS = 10,
    localparam int DW = DUTY_FRACTION_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fktc_pkg::fktc_cmd_t  cmd,
    output fktc_pkg::fktc_stat_t stat,
    input  logic [1:0]           tach_edges,
    input  logic                 request_valid,
    input  logic [DW-1:0]        duty_request,
    input  logic [15:0]          top_value,
    input  logic [15:0]          max_rpm,
    input  logic                 sense_enabled,
    input  logic [DW-1:0]        kick_level,
    input  logic [15:0]          kick_ms,
    input  logic [15:0]          window_ms,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [15:0]          compare_value,
    output logic [DW-1:0]        applied_duty,
    output logic [15:0]          speed_rpm,
    output logic                 kicking,
    output logic                 rpm_updated
);
    import fktc_pkg::*;

    localparam int DFB = DUTY_FRACTION_BITS;
    localparam int MBW = (DW > 15) ? DW : 15;
    localparam int PW  = 16 + MBW;
    localparam logic [DW-1:0] DUTY_FULL = {1'b1, {DFB{1'b0}}};

    logic [1:0]            edges_in_reg;
    logic                  req_valid_in_reg;
    logic [DW-1:0]         req_in_reg;

    logic [DW-1:0]         duty_reg, duty_next;
    logic [DW-1:0]         target_reg, target_next;
    logic                  kick_reg, kick_next;
    logic [15:0]           kick_timer_reg, kick_timer_next;
    logic [15:0]           win_timer_reg, win_timer_next;
    logic [15:0]           edge_cnt_reg, edge_cnt_next;
    logic [15:0]           meas_rpm_reg;
    logic                  win_closed_reg;
    logic [15:0]           edge_snap_reg;
    logic [15:0]           den_reg;

    logic [PW-1:0]         prod_reg;
    logic [15:0]           mul_a;
    logic [MBW-1:0]        mul_b;

    logic [DIVIDEND_W-1:0] div_q_reg;
    logic [15:0]           div_rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [16:0]           div_sh;
    logic [16:0]           div_diff;

    logic [15:0]           cmp_reg;
    logic                  m_tvalid_reg;
    logic [15:0]           out_cmp_reg;
    logic [DW-1:0]         out_duty_reg;
    logic [15:0]           out_speed_reg;
    logic                  out_kick_reg;
    logic                  out_upd_reg;

    logic [DW-1:0]         req_c;
    logic [DW-1:0]         level_c;
    logic [15:0]           est_c;
    logic                  stopped;
    logic                  started;
    logic [16:0]           edge_sum;
    logic [15:0]           edge_sat;
    logic [15:0]           win_inc;
    logic                  closing;

    assign req_c   = (req_in_reg > DUTY_FULL) ? DUTY_FULL : req_in_reg;
    assign level_c = (kick_level > DUTY_FULL) ? DUTY_FULL : kick_level;
    assign est_c   = prod_reg[DFB +: 16];
    assign stopped = sense_enabled ? (meas_rpm_reg == 16'd0) : (est_c == 16'd0);

    assign edge_sum = {1'b0, edge_cnt_reg} + 17'(edges_in_reg);
    assign edge_sat = edge_sum[16] ? 16'hFFFF : edge_sum[15:0];
    assign win_inc  = (win_timer_reg != 16'hFFFF) ? win_timer_reg + 16'd1 : win_timer_reg;
    assign closing  = sense_enabled && (win_inc >= window_ms);

    always_comb begin
        duty_next       = duty_reg;
        target_next     = target_reg;
        kick_next       = kick_reg;
        kick_timer_next = kick_timer_reg;
        started         = 1'b0;
        if (req_valid_in_reg) begin
            if (req_c == '0) begin
                duty_next   = '0;
                kick_next   = 1'b0;
                target_next = '0;
            end else if (stopped && req_c < level_c) begin
                target_next     = req_c;
                kick_timer_next = 16'd0;
                kick_next       = 1'b1;
                duty_next       = level_c;
                started         = 1'b1;
            end else if (kick_reg && req_c >= level_c) begin
                kick_next   = 1'b0;
                target_next = '0;
                duty_next   = req_c;
            end else if (kick_reg) begin
                target_next = req_c;
            end else begin
                duty_next = req_c;
            end
        end
        if (kick_next && !started) begin
            if (kick_timer_reg != 16'hFFFF) begin
                kick_timer_next = kick_timer_reg + 16'd1;
            end
            if (kick_timer_next >= kick_ms) begin
                duty_next   = target_next;
                target_next = '0;
                kick_next   = 1'b0;
            end
        end
    end

    always_comb begin
        edge_cnt_next  = edge_cnt_reg;
        win_timer_next = win_timer_reg;
        if (sense_enabled) begin
            if (closing) begin
                edge_cnt_next  = 16'd0;
                win_timer_next = 16'd0;
            end else begin
                edge_cnt_next  = edge_sat;
                win_timer_next = win_inc;
            end
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            MUL_EST: begin
                mul_a = max_rpm;
                mul_b = MBW'(duty_reg);
            end
            MUL_EDGE: begin
                mul_a = edge_snap_reg;
                mul_b = MBW'(RPM_PER_EDGE_MS);
            end
            MUL_CMP: begin
                mul_a = top_value;
                mul_b = MBW'(duty_reg);
            end
            default: begin
                mul_a = max_rpm;
                mul_b = MBW'(duty_reg);
            end
        endcase
    end

    assign div_sh   = {div_rem_reg, div_q_reg[DIVIDEND_W-1]};
    assign div_diff = div_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg       <= '0;
            target_reg     <= '0;
            kick_reg       <= 1'b0;
            kick_timer_reg <= 16'd0;
            win_timer_reg  <= 16'd0;
            edge_cnt_reg   <= 16'd0;
            meas_rpm_reg   <= 16'd0;
            win_closed_reg <= 1'b0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.upd) begin
                duty_reg       <= duty_next;
                target_reg     <= target_next;
                kick_reg       <= kick_next;
                kick_timer_reg <= kick_timer_next;
                win_timer_reg  <= win_timer_next;
                edge_cnt_reg   <= edge_cnt_next;
                win_closed_reg <= closing;
            end
            if (cmd.div_init) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.div_fin && div_q_reg[DIVIDEND_W-1:16] == '0) begin
                meas_rpm_reg <= div_q_reg[15:0];
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            edges_in_reg     <= tach_edges;
            req_valid_in_reg <= request_valid;
            req_in_reg       <= duty_request;
        end
        if (cmd.upd && closing) begin
            edge_snap_reg <= edge_sat;
            den_reg       <= win_inc;
        end
        if (cmd.mul_en) begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (cmd.div_init) begin
            div_q_reg   <= prod_reg[DIVIDEND_W-1:0];
            div_rem_reg <= 16'd0;
        end else if (cmd.div_step) begin
            if (!div_diff[16]) begin
                div_rem_reg <= div_diff[15:0];
                div_q_reg   <= {div_q_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= div_sh[15:0];
                div_q_reg   <= {div_q_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
        if (cmd.cmp_load) begin
            cmp_reg <= prod_reg[DFB +: 16];
        end
        if (cmd.out_load) begin
            out_cmp_reg   <= cmp_reg;
            out_duty_reg  <= duty_reg;
            out_speed_reg <= sense_enabled ? meas_rpm_reg : est_c;
            out_kick_reg  <= kick_reg;
            out_upd_reg   <= win_closed_reg;
        end
    end

    assign stat.win_closed = win_closed_reg;
    assign stat.div_last   = (div_cnt_reg == DIV_LAST);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid      = m_tvalid_reg;
    assign compare_value = out_cmp_reg;
    assign applied_duty  = out_duty_reg;
    assign speed_rpm     = out_speed_reg;
    assign kicking       = out_kick_reg;
    assign rpm_updated   = out_upd_reg;

    a_win_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.upd) && win_closed_reg |-> edge_cnt_reg == 16'd0 && win_timer_reg == 16'd0)
        else $error("window closed without clearing its counters");

    a_target_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !kick_reg |-> target_reg == '0)
        else $error("ramp target left over outside a kick");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> div_rem_reg < den_reg)
        else $error("divider remainder not below divisor");

endmodule
